@@ rtl/pla_pkg.sv @@
`timescale 1ns / 1ps

package pla_pkg;

   // Point count field width and its saturation value
   localparam int unsigned COUNT_WIDTH = 16;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;         // capture the item, form |dx| and |dy|
      logic square_x;     // dx * dx through the shared multiplier
      logic square_y;     // dy * dy through the shared multiplier
      logic sum_squares;  // form the radicand, clear the root unit
      logic root_step;    // one root bit from two radicand bits
      logic publish;      // update total and count, load the output register
   } pla_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic have_prev;    // a previous point is held
      logic out_free;     // output register can take an item this cycle
   } pla_status_type;

endpackage

@@ rtl/pla_controller.sv @@
`timescale 1ns / 1ps

module pla_controller
   import pla_pkg::*;
#(
   parameter int unsigned COORD_WIDTH = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_start_path,
   output logic           req_stall,
   input  pla_status_type status,
   output pla_cmd_type    cmd
);

   // Root digits: one per result bit
   localparam int unsigned ROOT_STEPS = COORD_WIDTH + 1;
   localparam int unsigned STEP_W     = $clog2(ROOT_STEPS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQX,
      ST_SQY,
      ST_SUM,
      ST_ROOT,
      ST_ACCUM
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              accept;

   // Hold off the sender during reset and while an item is in work
   assign req_stall = reset || (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // Decode commands and next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               // first point of a path has no segment: skip the root
               if (req_start_path || !status.have_prev) begin
                  state_in = ST_ACCUM;
               end else begin
                  state_in = ST_SQX;
               end
            end
         end
         ST_SQX: begin
            cmd.square_x = 1'b1;
            state_in     = ST_SQY;
         end
         ST_SQY: begin
            cmd.square_y = 1'b1;
            state_in     = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum_squares = 1'b1;
            step_in         = STEP_W'(ROOT_STEPS - 1);
            state_in        = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (step_ff == '0) begin
               state_in = ST_ACCUM;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_ACCUM: begin
            // hold until the output register has room
            if (status.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and digit counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

@@ rtl/pla_datapath.sv @@
`timescale 1ns / 1ps

module pla_datapath
   import pla_pkg::*;
#(
   parameter int unsigned COORD_WIDTH = 16,
   parameter int unsigned TOTAL_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pla_cmd_type                   cmd,
   output pla_status_type                status,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   input  logic                          req_start_path,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [COORD_WIDTH:0]          rsp_segment_length,
   output logic [TOTAL_WIDTH-1:0]        rsp_total_length,
   output logic [COUNT_WIDTH-1:0]        rsp_points_seen,
   output logic                          rsp_saturated
);

   localparam int unsigned SEG_W  = COORD_WIDTH + 1;
   localparam int unsigned SQ_W   = 2 * COORD_WIDTH;
   localparam int unsigned RAD_W  = 2 * COORD_WIDTH + 2;
   localparam int unsigned REM_W  = COORD_WIDTH + 4;
   localparam int unsigned ACC_W  = ((TOTAL_WIDTH > SEG_W) ? TOTAL_WIDTH : SEG_W) + 1;

   localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = '1;

   // Path state
   logic [COORD_WIDTH-1:0] prev_x_ff, prev_y_ff;
   logic                   have_prev_ff;
   logic [TOTAL_WIDTH-1:0] total_ff, total_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   zero_seg_ff;

   // Working registers
   logic [COORD_WIDTH-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [SQ_W-1:0]        sqx_ff, sqy_ff, product;
   logic [RAD_W-1:0]       rad_ff;
   logic [REM_W-1:0]       rem_ff, rem_in, rem_shift, trial;
   logic [SEG_W-1:0]       root_ff, root_in;

   // Output register
   logic                   rsp_valid_ff;
   logic [SEG_W-1:0]       seg_out_ff;
   logic [TOTAL_WIDTH-1:0] total_out_ff;
   logic [COUNT_WIDTH-1:0] count_out_ff;
   logic                   sat_out_ff;

   logic [SEG_W-1:0]       seg;
   logic [ACC_W-1:0]       acc_sum;

   assign status.have_prev = have_prev_ff;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   // Magnitude of the coordinate differences
   function automatic logic [COORD_WIDTH-1:0] abs_diff(
      input logic [COORD_WIDTH-1:0] a,
      input logic [COORD_WIDTH-1:0] b
   );
      logic [COORD_WIDTH:0] d;
      d = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
      if (d[COORD_WIDTH]) begin
         d = ~d + 1'b1;
      end
      return d[COORD_WIDTH-1:0];
   endfunction

   assign dx_in = abs_diff(req_point_x, prev_x_ff);
   assign dy_in = abs_diff(req_point_y, prev_y_ff);

   // Shared squarer
   assign product = (cmd.square_y ? dy_ff : dx_ff) * (cmd.square_y ? dy_ff : dx_ff);

   // One digit of the restoring square root
   assign rem_shift = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign trial     = {1'b0, root_ff, 2'b01};
   always_comb begin
      if (rem_shift >= trial) begin
         rem_in  = rem_shift - trial;
         root_in = {root_ff[SEG_W-2:0], 1'b1};
      end else begin
         rem_in  = rem_shift;
         root_in = {root_ff[SEG_W-2:0], 1'b0};
      end
   end

   // Accumulate with saturation
   assign seg     = zero_seg_ff ? '0 : root_ff;
   assign acc_sum = ACC_W'(total_ff) + ACC_W'(seg);
   always_comb begin
      if (acc_sum > ACC_W'(TOTAL_MAX)) begin
         total_in = TOTAL_MAX;
      end else begin
         total_in = acc_sum[TOTAL_WIDTH-1:0];
      end
      if (count_ff == COUNT_MAX) begin
         count_in = count_ff;
      end else begin
         count_in = count_ff + 1'b1;
      end
   end

   // Path state: previous point, total, count
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         have_prev_ff <= 1'b0;
         total_ff     <= '0;
         count_ff     <= '0;
      end else if (cmd.load) begin
         prev_x_ff    <= req_point_x;
         prev_y_ff    <= req_point_y;
         have_prev_ff <= 1'b1;
         if (req_start_path) begin
            total_ff <= '0;
            count_ff <= '0;
         end
      end else if (cmd.publish) begin
         total_ff <= total_in;
         count_ff <= count_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dx_ff       <= dx_in;
         dy_ff       <= dy_in;
         zero_seg_ff <= req_start_path || !have_prev_ff;
      end
      if (cmd.square_x) begin
         sqx_ff <= product;
      end
      if (cmd.square_y) begin
         sqy_ff <= product;
      end
      if (cmd.sum_squares) begin
         rad_ff  <= RAD_W'(sqx_ff) + RAD_W'(sqy_ff);
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cmd.root_step) begin
         rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   // Output register: load on publish, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         seg_out_ff   <= seg;
         total_out_ff <= total_in;
         count_out_ff <= count_in;
         sat_out_ff   <= (total_in == TOTAL_MAX) || (count_in == COUNT_MAX);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_segment_length = seg_out_ff;
   assign rsp_total_length   = total_out_ff;
   assign rsp_points_seen    = count_out_ff;
   assign rsp_saturated      = sat_out_ff;

   // The first point of a path never carries a segment
   a_first_point_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (count_out_ff == COUNT_WIDTH'(1)) |-> (seg_out_ff == '0))
      else $error("first point of a path with non-zero segment");

   // Saturation flag agrees with the published total and count
   a_sat_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         (sat_out_ff == ((total_out_ff == TOTAL_MAX) || (count_out_ff == COUNT_MAX))))
      else $error("saturation flag inconsistent");

   // Count only grows unless a new path starts
   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && req_start_path) |=> (count_ff >= $past(count_ff)))
      else $error("point count fell without a path start");

   // Total never falls between path starts
   a_total_monotonic: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && req_start_path) |=> (total_ff >= $past(total_ff)))
      else $error("running total fell without a path start");

endmodule

@@ rtl/path_length_accumulator_unit.sv @@
`timescale 1ns / 1ps
// Path length accumulator: Euclidean length of a path of 2-D points in Q8.8.
//
// Request channel (req_): one point per item, with req_start_path marking the
// first point of a new path. An item is taken at a clock edge where req_valid
// is high and req_stall is low. Response channel (rsp_): one item per point
// with the segment length, the running total, the point count and a
// saturation flag; it is taken where rsp_valid is high and rsp_stall is low.
//
// A point that starts a path (or the first after reset) skips the root and
// goes straight to the publish step; any other point passes two squaring
// steps on the one shared multiplier, the radicand add, COORD_WIDTH + 1
// digit steps of the square root and the publish step. One point is in
// work at a time: the controller takes a new point only in idle, after the
// last one has been published.
// A finished item sits in the output register; the next point is taken
// meanwhile, and only the publish step waits while rsp_stall is high.
//
// Reset clears the previous point, the total, the count and both valid flags
// and holds req_stall high; the block takes items on the first cycle after.

module path_length_accumulator_unit
   import pla_pkg::*;
#(
   parameter int unsigned COORD_WIDTH = 16,
   parameter int unsigned TOTAL_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   input  logic                          req_start_path,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [COORD_WIDTH:0]          rsp_segment_length,
   output logic [TOTAL_WIDTH-1:0]        rsp_total_length,
   output logic [COUNT_WIDTH-1:0]        rsp_points_seen,
   output logic                          rsp_saturated
);

   pla_cmd_type    cmd;
   pla_status_type status;

   // Sequence the work on one item
   pla_controller #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_controller (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_start_path (req_start_path),
      .req_stall      (req_stall),
      .status         (status),
      .cmd            (cmd)
   );

   // Differences, squares, root, total and output register
   pla_datapath #(
      .COORD_WIDTH (COORD_WIDTH),
      .TOTAL_WIDTH (TOTAL_WIDTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_point_x        (req_point_x),
      .req_point_y        (req_point_y),
      .req_start_path     (req_start_path),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_segment_length (rsp_segment_length),
      .rsp_total_length   (rsp_total_length),
      .rsp_points_seen    (rsp_points_seen),
      .rsp_saturated      (rsp_saturated)
   );

endmodule
